/* src/qte_pkg.sv */
// Shared types, constants and the arctangent table for the quaternion-to-Euler block.
package qte_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int CORDIC_STAGES = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;

  localparam int QuatW  = 16;
  localparam int ProdW  = 32;
  localparam int SumW   = 34;
  localparam int VW     = 30;
  localparam int RootW  = 29;
  localparam int RadW   = 58;
  localparam int SqrtStages = 29;
  localparam int CordW  = 40;
  localparam int AngW   = 34;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  localparam logic signed [SumW-1:0] OneQ28    = SumW'(268435456);
  localparam logic signed [AngW-1:0] PiQ30     = AngW'(64'd3373259426);
  localparam logic signed [17:0]     PiQ13     = 18'sd25736;
  localparam logic signed [17:0]     HalfPiQ13 = 18'sd12868;

  typedef struct packed {
    logic signed [SumW-1:0] hn;
    logic signed [SumW-1:0] hd;
    logic signed [SumW-1:0] bn;
    logic signed [SumW-1:0] bd;
    logic signed [VW-1:0]   v;
  } qte_item_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [AngW-1:0] atan_q30(input int unsigned i);
    logic signed [AngW-1:0] r;
    unique case (i)
      0:  r = AngW'(843314856);
      1:  r = AngW'(497837829);
      2:  r = AngW'(263043836);
      3:  r = AngW'(133525158);
      4:  r = AngW'(67021686);
      5:  r = AngW'(33543515);
      6:  r = AngW'(16775850);
      7:  r = AngW'(8388437);
      8:  r = AngW'(4194282);
      9:  r = AngW'(2097149);
      10: r = AngW'(1048575);
      11: r = AngW'(524287);
      12: r = AngW'(262143);
      13: r = AngW'(131071);
      14: r = AngW'(65535);
      15: r = AngW'(32767);
      16: r = AngW'(16383);
      17: r = AngW'(8191);
      18: r = AngW'(4095);
      19: r = AngW'(2047);
      20: r = AngW'(1023);
      21: r = AngW'(511);
      22: r = AngW'(255);
      23: r = AngW'(127);
      24: r = AngW'(63);
      25: r = AngW'(31);
      26: r = AngW'(15);
      27: r = AngW'(7);
      28: r = AngW'(3);
      29: r = AngW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/qte_front.sv */
// Front end: accepts quaternions, forms the products and the atan2/asin operands.
module qte_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [qte_pkg::QuatW-1:0] quat_x_i,
  input  logic signed [qte_pkg::QuatW-1:0] quat_y_i,
  input  logic signed [qte_pkg::QuatW-1:0] quat_z_i,
  input  logic signed [qte_pkg::QuatW-1:0] quat_w_i,
  input  logic [qte_pkg::QCntW-1:0]        q_count_i,
  output logic                             push_o,
  output qte_pkg::qte_item_t               item_o
);
  import qte_pkg::*;

  logic accept;
  logic p_valid_q;
  logic signed [ProdW-1:0] xx_q, yy_q, zz_q, ww_q, xy_q, zw_q, yz_q, xw_q, yw_q, xz_q;
  logic s_valid_q;
  qte_item_t s_item_q;
  qte_item_t s_item_d;
  logic signed [SumW-1:0] v_full;
  logic [QCntW:0] used;

  // queue slots in use or already spoken for by items still in the front stages
  assign used   = {1'b0, q_count_i} + (QCntW+1)'(p_valid_q) + (QCntW+1)'(s_valid_q);
  assign busy   = used >= (QCntW+1)'(QDepth);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      p_valid_q <= accept;
      s_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
    ww_q <= quat_w_i * quat_w_i;
    xy_q <= quat_x_i * quat_y_i;
    zw_q <= quat_z_i * quat_w_i;
    yz_q <= quat_y_i * quat_z_i;
    xw_q <= quat_x_i * quat_w_i;
    yw_q <= quat_y_i * quat_w_i;
    xz_q <= quat_x_i * quat_z_i;
    s_item_q <= s_item_d;
  end

  always_comb begin
    s_item_d.hn = (SumW'(xy_q) + SumW'(zw_q)) <<< 1;
    s_item_d.hd = SumW'(xx_q) - SumW'(yy_q) - SumW'(zz_q) + SumW'(ww_q);
    s_item_d.bn = (SumW'(yz_q) + SumW'(xw_q)) <<< 1;
    s_item_d.bd = SumW'(zz_q) + SumW'(ww_q) - SumW'(xx_q) - SumW'(yy_q);
    v_full = (SumW'(yw_q) - SumW'(xz_q)) <<< 1;
    priority if (v_full > OneQ28) begin
      s_item_d.v = VW'(OneQ28);
    end else if (v_full < -OneQ28) begin
      s_item_d.v = VW'(-OneQ28);
    end else begin
      s_item_d.v = VW'(v_full);
    end
  end

  assign push_o = s_valid_q;
  assign item_o = s_item_q;

endmodule

/* src/qte_fifo.sv */
// Short queue between the front end and the back end.
module qte_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  qte_pkg::qte_item_t        item_i,
  input  logic                      pop_i,
  output logic                      empty_o,
  output logic [qte_pkg::QCntW-1:0] count_o,
  output qte_pkg::qte_item_t        item_o
);
  import qte_pkg::*;

  qte_item_t mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic do_pop;

  assign empty_o = cnt_q == '0;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign count_o = cnt_q;
  assign item_o  = mem_q[rd_q];

endmodule

/* src/qte_sqrt.sv */
// Pipelined floor square root, one result bit per stage.
module qte_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [qte_pkg::RadW-1:0]  rad_i,
  output logic                      valid_o,
  output logic [qte_pkg::RootW-1:0] root_o
);
  import qte_pkg::*;

  logic            vld_q [SqrtStages+1];
  logic [RadW-1:0] rem_q [SqrtStages+1];
  logic [RadW-1:0] res_q [SqrtStages+1];

  assign vld_q[0] = valid_i;
  assign rem_q[0] = rad_i;
  assign res_q[0] = '0;

  for (genvar s = 0; s < SqrtStages; s++) begin : g_stage
    localparam logic [RadW-1:0] Bit = RadW'(1) << (2 * (SqrtStages - 1 - s));
    logic [RadW-1:0] trial;
    logic [RadW-1:0] rem_d, res_d;
    always_comb begin
      trial = res_q[s] + Bit;
      if (rem_q[s] >= trial) begin
        rem_d = rem_q[s] - trial;
        res_d = (res_q[s] >> 1) + Bit;
      end else begin
        rem_d = rem_q[s];
        res_d = res_q[s] >> 1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+1] <= 1'b0;
      else         vld_q[s+1] <= vld_q[s];
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d;
      res_q[s+1] <= res_d;
    end
  end

  assign valid_o = vld_q[SqrtStages];
  assign root_o  = res_q[SqrtStages][RootW-1:0];

endmodule

/* src/qte_cordic.sv */
// Unrolled vectoring CORDIC: atan2(y, x) in Q30 radians.
module qte_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [qte_pkg::SumW-1:0]  y_i,
  input  logic signed [qte_pkg::SumW-1:0]  x_i,
  output logic                             valid_o,
  output logic signed [qte_pkg::AngW-1:0]  angle_o
);
  import qte_pkg::*;

  logic                   vld_q  [CORDIC_STAGES+1];
  logic                   zero_q [CORDIC_STAGES+1];
  logic signed [CordW-1:0] x_q   [CORDIC_STAGES+1];
  logic signed [CordW-1:0] y_q   [CORDIC_STAGES+1];
  logic signed [AngW-1:0]  z_q   [CORDIC_STAGES+1];

  // left half-plane: rotate by pi first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else         vld_q[0] <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      x_q[0] <= -CordW'(x_i);
      y_q[0] <= -CordW'(y_i);
      z_q[0] <= (y_i >= 0) ? PiQ30 : -PiQ30;
    end else begin
      x_q[0] <= CordW'(x_i);
      y_q[0] <= CordW'(y_i);
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
    localparam logic signed [AngW-1:0] Atan = atan_q30(i);
    logic signed [CordW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[i+1] <= 1'b0;
      else         vld_q[i+1] <= vld_q[i];
    end
    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + Atan;
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - Atan;
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STAGES];
  assign angle_o = zero_q[CORDIC_STAGES] ? '0 : z_q[CORDIC_STAGES];

endmodule

/* src/qte_back.sv */
// Back end: pitch cosine via square root, three CORDICs, rounding and saturation.
module qte_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  qte_pkg::qte_item_t      item_i,
  output logic                    pop_o,
  output logic                    done_o,
  output logic signed [15:0]      bank_angle_o,
  output logic signed [14:0]      pitch_angle_o,
  output logic signed [15:0]      heading_angle_o
);
  import qte_pkg::*;

  localparam logic [RadW-1:0] OneSqQ56 = RadW'(1) << 56;

  logic m_valid_q, n_valid_q;
  qte_item_t m_item_q, n_item_q;
  logic signed [2*VW-1:0] v_sq;
  logic [RadW-1:0] vsq_q, rad_q;
  logic sq_valid;
  logic [RootW-1:0] root;
  qte_item_t dly_q [SqrtStages+1];
  qte_item_t c_item;
  logic h_valid, b_valid, p_valid;
  logic signed [AngW-1:0] h_ang, b_ang, p_ang;
  logic out_valid_q;
  logic signed [15:0] bank_q, head_q;
  logic signed [14:0] pitch_q;

  function automatic logic signed [17:0] to_q13(input logic signed [AngW-1:0] a,
                                               input logic signed [17:0] lim);
    logic signed [AngW:0] t;
    logic signed [17:0]   r;
    t = (AngW+1)'(a) + (AngW+1)'(65536);
    r = 18'(t >>> 17);
    if (r > lim)       r = lim;
    else if (r < -lim) r = -lim;
    return r;
  endfunction

  // back end never stalls: drain one item per cycle
  assign pop_o = !q_empty_i;

  // full-width square of the clamped pitch sine
  assign v_sq = item_i.v * item_i.v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      n_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      m_valid_q   <= pop_o;
      n_valid_q   <= m_valid_q;
      out_valid_q <= h_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    m_item_q <= item_i;
    vsq_q    <= RadW'(v_sq);
    n_item_q <= m_item_q;
    rad_q    <= OneSqQ56 - vsq_q;
  end

  qte_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (n_valid_q),
    .rad_i   (rad_q),
    .valid_o (sq_valid),
    .root_o  (root)
  );

  assign dly_q[0] = n_item_q;
  for (genvar s = 0; s < SqrtStages; s++) begin : g_dly
    always_ff @(posedge clk_i) dly_q[s+1] <= dly_q[s];
  end
  assign c_item = dly_q[SqrtStages];

  qte_cordic u_head (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sq_valid),
    .y_i (c_item.hn), .x_i (c_item.hd), .valid_o (h_valid), .angle_o (h_ang)
  );

  qte_cordic u_bank (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sq_valid),
    .y_i (c_item.bn), .x_i (c_item.bd), .valid_o (b_valid), .angle_o (b_ang)
  );

  qte_cordic u_pitch (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (sq_valid),
    .y_i (SumW'(c_item.v)), .x_i (SumW'({1'b0, root})),
    .valid_o (p_valid), .angle_o (p_ang)
  );

  always_ff @(posedge clk_i) begin
    head_q  <= 16'(to_q13(h_ang, PiQ13));
    bank_q  <= 16'(to_q13(b_ang, PiQ13));
    pitch_q <= 15'(to_q13(p_ang, HalfPiQ13));
  end

  assign done_o          = out_valid_q;
  assign bank_angle_o    = bank_q;
  assign pitch_angle_o   = pitch_q;
  assign heading_angle_o = head_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) h_valid == b_valid)
    else $error("heading and bank pipelines out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni) h_valid == p_valid)
    else $error("heading and pitch pipelines out of step");

endmodule

/* src/quaternion_to_euler.sv */
// Top level: quaternion (Q2.14) to bank/heading angles (Q3.13 radians) and pitch angle (Q2.13 radians).
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   request  | start / busy       | quat_x_i, quat_y_i, quat_z_i, quat_w_i
//   result   | done_o (one cycle) | bank_angle_o, pitch_angle_o, heading_angle_o
//
// One transaction per cycle sustained. From accept to done_o an item passes through
// the front products and sums, the queue, v^2 and radicand,
// a 29-stage square root for the pitch cosine, the CORDIC stages and output rounding.
// Reset clears all valid bits and the queue; results in flight are dropped.
// The receiver cannot stall; busy rises only when the queue would overflow.
module quaternion_to_euler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [qte_pkg::QuatW-1:0] quat_x_i,
  input  logic signed [qte_pkg::QuatW-1:0] quat_y_i,
  input  logic signed [qte_pkg::QuatW-1:0] quat_z_i,
  input  logic signed [qte_pkg::QuatW-1:0] quat_w_i,
  output logic                             done_o,
  output logic signed [15:0]               bank_angle_o,
  output logic signed [14:0]               pitch_angle_o,
  output logic signed [15:0]               heading_angle_o
);
  import qte_pkg::*;

  logic push, pop, q_empty;
  logic [QCntW-1:0] q_count;
  qte_item_t f_item, q_item;

  qte_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .quat_x_i  (quat_x_i),
    .quat_y_i  (quat_y_i),
    .quat_z_i  (quat_z_i),
    .quat_w_i  (quat_w_i),
    .q_count_i (q_count),
    .push_o    (push),
    .item_o    (f_item)
  );

  qte_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .pop_i   (pop),
    .empty_o (q_empty),
    .count_o (q_count),
    .item_o  (q_item)
  );

  qte_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .item_i          (q_item),
    .pop_o           (pop),
    .done_o          (done_o),
    .bank_angle_o    (bank_angle_o),
    .pitch_angle_o   (pitch_angle_o),
    .heading_angle_o (heading_angle_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(push && (q_count == QCntW'(QDepth)) && !pop))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> (pitch_angle_o <= 15'sd12868) && (pitch_angle_o >= -15'sd12868))
    else $error("pitch out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> (heading_angle_o <= 16'sd25736) && (heading_angle_o >= -16'sd25736))
    else $error("heading out of range");

endmodule
